>>> rtl/ssm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the substring search matcher.
// No dependencies; imported by ssm_cell and substring_search_matcher_core.
package ssm_pkg;

    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 4;
    localparam int PAT_W     = 64;
    localparam int START_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

    typedef struct packed {
        logic adv;
        logic clr;
    } t_cell_ctrl;

endpackage

>>> rtl/substring_search_matcher_core.sv
`timescale 1ns / 1ps
// Top level of the streaming substring search matcher.
// Depends on ssm_pkg and ssm_cell.
//
// The text arrives on the slave stream one character per transaction, with
// tlast on the final character. The pattern (up to eight bytes) and its length
// are written through the configuration port; the user must do so only while
// the block is idle, which the block does not enforce. A chain of MAX_PATTERN
// cells holds the shift-and partial-match bits; every character is compared
// against all pattern bytes in parallel, each cell takes its neighbor's bit,
// and one character is accepted per clock cycle while s_axis_tready is high.
// At most one result transaction is produced per text: the start index of the
// first match, or a not-found report on the last character, registered and
// shown on the master stream in the cycle after its character. An output
// register separates the two sides: while a result waits, input is still
// accepted as long as the register is empty or is drained in that cycle. When
// the receiver stalls with a result pending, s_axis_tready drops. Synchronous
// reset clears the configuration, stream state and output valid flag. After a
// tlast transaction the stream state returns to its reset values while the configuration is kept.
module substring_search_matcher_core
    import ssm_pkg::*;
#(
    parameter int              MAX_PATTERN = 8,
    parameter longint unsigned MAX_TEXT    = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] text_char
    input  logic                 s_axis_tlast,   // last_char
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // [15:0] match_start, [16] overflow
    output logic [0:0]           m_axis_tuser    // [0] found
);

    localparam int IDX_W = $clog2(MAX_TEXT + 1);
    localparam logic [IDX_W-1:0] TEXT_LIM = IDX_W'(MAX_TEXT);
    localparam logic [IDX_W-1:0] POS_MAX  = IDX_W'(MAX_TEXT - 1);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_PATTERN);

    logic [PAT_W-1:0] r_pat;
    logic [LEN_W-1:0] r_len;

    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_found, n_found;
    logic             r_ovf, n_ovf;

    logic               r_out_valid, n_out_valid;
    logic               r_out_found, n_out_found;
    logic [START_W-1:0] r_out_start, n_out_start;
    logic               r_out_ovf, n_out_ovf;

    logic                   w_in_acc;
    logic                   w_work;
    logic                   w_hit;
    logic                   w_load;
    logic [LEN_W-1:0]       w_len;
    logic [IDX_W-1:0]       w_pos;
    logic [IDX_W-1:0]       w_start;
    logic [63:0]            w_start_ext;
    logic                   w_start_sat;
    t_cell_ctrl             w_ctrl;
    logic [MAX_PATTERN-1:0] w_next;
    logic [MAX_PATTERN-1:0] w_match;
    logic [MAX_PATTERN-1:0] w_en;
    logic [MAX_PATTERN-1:0] w_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= '0;
            r_len <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PATTERN_BYTES:  r_pat <= i_cfg_data;
                REG_PATTERN_LENGTH: r_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_len = (r_len > LEN_MAX) ? LEN_MAX : r_len;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_work        = w_in_acc && !r_found;

    assign w_ctrl.adv = w_work && (w_len != '0);
    assign w_ctrl.clr = w_in_acc && s_axis_tlast;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
            assign w_en[k]  = (w_len > LEN_W'(k));
            assign w_sel[k] = (w_len == LEN_W'(k + 1));
            ssm_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl),
                .i_char     (s_axis_tdata),
                .i_pat_char (r_pat[CHAR_W*k +: CHAR_W]),
                .i_en       (w_en[k]),
                .i_prev     ((k == 0) ? 1'b1 : w_match[(k == 0) ? 0 : k - 1]),
                .o_next     (w_next[k]),
                .o_match    (w_match[k])
            );
        end
    endgenerate

    assign w_hit       = w_work && ((w_len == '0) || (|(w_next & w_sel)));
    assign w_pos       = (r_idx >= TEXT_LIM) ? POS_MAX : r_idx;
    assign w_start     = (w_len == '0) ? '0 : (w_pos - IDX_W'(w_len - 1'b1));
    assign w_start_ext = 64'(w_start);
    assign w_start_sat = (w_start_ext > 64'hFFFF);
    assign w_load      = w_hit || (w_work && s_axis_tlast);

    always_comb begin
        n_idx   = r_idx;
        n_found = r_found;
        n_ovf   = r_ovf;
        if (w_work) begin
            if (r_idx >= TEXT_LIM) begin
                n_ovf = 1'b1;
            end else begin
                n_idx = r_idx + 1'b1;
            end
            if (w_hit) begin
                n_found = 1'b1;
            end
        end
        if (w_ctrl.clr) begin
            n_idx   = '0;
            n_found = 1'b0;
            n_ovf   = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_start = r_out_start;
        n_out_ovf   = r_out_ovf;
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out_found = w_hit;
            if (w_hit) begin
                n_out_start = w_start_sat ? 16'hFFFF : START_W'(w_start_ext);
                n_out_ovf   = w_start_sat || r_ovf || (r_idx >= TEXT_LIM);
            end else begin
                n_out_start = '0;
                n_out_ovf   = r_ovf || (r_idx >= TEXT_LIM);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_found <= n_out_found;
        r_out_start <= n_out_start;
        r_out_ovf   <= n_out_ovf;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_ovf, r_out_start};
    assign m_axis_tuser  = r_out_found;

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_start == '0))
        else $error("not-found result carries a nonzero start index");

    a_found_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hit && !s_axis_tlast) |=> r_found)
        else $error("match was reported but the found flag did not set");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tlast) |=> (r_idx == '0 && !r_found && !r_ovf && w_match == '0))
        else $error("stream state not cleared after the last character");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> !w_load)
        else $error("second result produced for one text");

    a_load_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_out_valid)
        else $error("result lost in the output register");

endmodule

>>> rtl/ssm_cell.sv
`timescale 1ns / 1ps
// One cell of the partial-match chain: holds one prefix-match bit.
// Depends on ssm_pkg for the character width and the cell control struct.
module ssm_cell
    import ssm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic [CHAR_W-1:0] i_char,
    input  logic [CHAR_W-1:0] i_pat_char,
    input  logic              i_en,
    input  logic              i_prev,
    output logic              o_next,
    output logic              o_match
);

    logic r_match;
    logic n_match;
    logic w_step;

    assign w_step = i_prev & i_en & (i_char == i_pat_char);

    always_comb begin
        priority if (i_ctrl.clr) begin
            n_match = 1'b0;
        end else if (i_ctrl.adv) begin
            n_match = w_step;
        end else begin
            n_match = r_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
    end

    assign o_next  = w_step;
    assign o_match = r_match;

endmodule
